// ----- rtl/mppq_pkg.sv -----
// Package for the multilevel priority process queue.
// Field widths, operation codes and controller/datapath interface structs.
// No dependencies.
package mppq_pkg;

    localparam int ID_W        = 8;
    localparam int USER_LEVELS = 3;
    localparam int NUM_LEVELS  = USER_LEVELS + 1;
    localparam int LVL_W       = 2;
    localparam int CNT_W       = 7;
    localparam int OP_W        = 2;

    localparam int IN_BITS     = ID_W + LVL_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ID_W + LVL_W + CNT_W + 2;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0]  OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0]  OP_FEEDBACK = 2'd1;
    localparam logic [OP_W-1:0]  OP_PICK     = 2'd2;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST = 7'd64;

    typedef struct packed {
        logic cap;        // capture the input beat
        logic exec_push;  // insert/requeue/no-op, emit result
        logic exec_pop;   // pop head, start queue memory read
        logic emit_pop;   // emit result with read data
    } t_cmd;

    typedef struct packed {
        logic pick_found; // captured op is a pick and a level is nonempty
        logic out_free;   // output register can take a beat
    } t_sts;

endpackage

// ----- rtl/mppq_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mppq_ctrl.sv -----
// Controller state machine for the multilevel priority process queue.
// Depends on mppq_pkg (t_cmd, t_sts).
module mppq_ctrl import mppq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.pick_found) begin
                    o_cmd.exec_pop = 1'b1;
                    n_state        = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.exec_push = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pop = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/mppq_dp.sv -----
// Datapath: level pointers and counts, shared queue memory, limit register,
// output register. Depends on mppq_pkg and mppq_ram.
module mppq_dp import mppq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [OP_W-1:0]  i_op,
    input  logic [ID_W-1:0]  i_proc_id,
    input  logic [LVL_W-1:0] i_priority_req,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_accepted,
    output logic [ID_W-1:0]  o_out_proc_id,
    output logic [LVL_W-1:0] o_out_priority,
    output logic [CNT_W-1:0] o_occupancy,
    output logic             o_all_empty,
    output logic             o_at_limit
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int MEM_D  = NUM_LEVELS << PTR_W;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] LIM_CAP =
        CNT_W'((QUEUE_DEPTH > CNT_MAX) ? CNT_MAX : QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    logic [OP_W-1:0]  r_op;
    logic [ID_W-1:0]  r_id;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] r_pick_lvl;
    logic [PTR_W-1:0] r_head [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail [NUM_LEVELS];
    logic [CNT_W-1:0] r_cnt  [NUM_LEVELS];
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_max_count;
    logic             r_out_valid;
    logic             r_accepted;
    logic [ID_W-1:0]  r_out_id;
    logic [LVL_W-1:0] r_out_pri;
    logic [CNT_W-1:0] r_occ;
    logic             r_all_empty;
    logic             r_at_limit;

    logic [LVL_W-1:0] lvl_in;
    logic [LVL_W-1:0] pick_lvl;
    logic             found;
    logic [CNT_W-1:0] eff_limit;
    logic             push_ok;
    logic             ram_we;
    logic [CNT_W-1:0] n_total;
    logic [ID_W-1:0]  ram_rdata;
    logic             out_free;

    // clamp to the lowest level, then demote a user-level requeue
    always_comb begin
        lvl_in = (i_priority_req > LVL_W'(USER_LEVELS)) ? LVL_W'(USER_LEVELS)
                                                        : i_priority_req;
        if (i_op == OP_FEEDBACK && lvl_in != '0 && lvl_in < LVL_W'(USER_LEVELS)) begin
            lvl_in = lvl_in + LVL_W'(1);
        end
    end

    // highest-priority nonempty level
    always_comb begin
        found    = 1'b0;
        pick_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[l] != '0) begin
                found    = 1'b1;
                pick_lvl = LVL_W'(l);
            end
        end
    end

    assign eff_limit = (r_max_count > LIM_CAP) ? LIM_CAP : r_max_count;
    assign push_ok   = (r_op == OP_INSERT || r_op == OP_FEEDBACK) && (r_total < eff_limit);
    assign ram_we    = i_cmd.exec_push && push_ok;

    always_comb begin
        n_total = r_total;
        if (ram_we) begin
            n_total = r_total + CNT_W'(1);
        end else if (i_cmd.exec_pop) begin
            n_total = r_total - CNT_W'(1);
        end
    end

    assign out_free         = !r_out_valid || i_out_ready;
    assign o_sts.out_free   = out_free;
    assign o_sts.pick_found = (r_op == OP_PICK) && found;

    mppq_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_D)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'({r_lvl, r_tail[r_lvl]})),
        .i_wdata (r_id),
        .i_re    (i_cmd.exec_pop),
        .i_raddr (ADDR_W'({pick_lvl, r_head[pick_lvl]})),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_total     <= '0;
            r_max_count <= MAX_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_count <= i_cfg_data;
            end
            if (ram_we) begin
                r_tail[r_lvl] <= next_ptr(r_tail[r_lvl]);
                r_cnt[r_lvl]  <= r_cnt[r_lvl] + CNT_W'(1);
            end
            if (i_cmd.exec_pop) begin
                r_head[pick_lvl] <= next_ptr(r_head[pick_lvl]);
                r_cnt[pick_lvl]  <= r_cnt[pick_lvl] - CNT_W'(1);
            end
            r_total <= n_total;
            if (i_cmd.exec_push || i_cmd.emit_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_op;
            r_id  <= i_proc_id;
            r_lvl <= lvl_in;
        end
        if (i_cmd.exec_pop) begin
            r_pick_lvl <= pick_lvl;
        end
        if (i_cmd.exec_push) begin
            r_accepted <= push_ok;
            r_out_id   <= '0;
            r_out_pri  <= push_ok ? r_lvl : '0;
        end else if (i_cmd.emit_pop) begin
            r_accepted <= 1'b1;
            r_out_id   <= ram_rdata;
            r_out_pri  <= r_pick_lvl;
        end
        if (i_cmd.exec_push || i_cmd.emit_pop) begin
            r_occ       <= n_total;
            r_all_empty <= (n_total == '0);
            r_at_limit  <= (n_total >= eff_limit);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_out_proc_id  = r_out_id;
    assign o_out_priority = r_out_pri;
    assign o_occupancy    = r_occ;
    assign o_all_empty    = r_all_empty;
    assign o_at_limit     = r_at_limit;

endmodule

// ----- rtl/multilevel_priority_process_queue_core.sv -----
// Top level of the multilevel priority process queue.
// Depends on mppq_pkg, mppq_ctrl, mppq_dp (which holds mppq_ram).
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    op, proc_id, priority_req
//  m_axis    out  m_axis_tvalid/m_axis_tready    accepted, id, priority, status
//  cfg       in   i_cfg_valid/o_cfg_ready        max_count
//
// Insert, requeue, unused ops and a pick that finds every level empty pass
// through capture and execute states: the result register loads on leaving
// execute and the next beat is taken back in idle. A pick that finds a process
// adds a read state for the registered read of the queue RAM.
// One operation is in flight at a time; s_axis_tready is high only when idle.
// A result waits in the output register while the next beat is taken; the
// next operation stalls at its result step until that register drains.
// Synchronous active-low reset; queue RAM contents are not cleared.
module multilevel_priority_process_queue_core import mppq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // proc_id, priority_req
    input  logic [OP_W-1:0]       s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_proc_id, out_priority,
                                                  // occupancy, all_empty, at_limit
    output logic [0:0]            m_axis_tuser,   // accepted
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_W-1:0]      i_cfg_data
);

    t_cmd             cmd;
    t_sts             sts;
    logic             accepted;
    logic [ID_W-1:0]  out_proc_id;
    logic [LVL_W-1:0] out_priority;
    logic [CNT_W-1:0] occupancy;
    logic             all_empty;
    logic             at_limit;

    assign o_cfg_ready = 1'b1;

    mppq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mppq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (s_axis_tuser),
        .i_proc_id      (s_axis_tdata[ID_W-1:0]),
        .i_priority_req (s_axis_tdata[ID_W +: LVL_W]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_accepted     (accepted),
        .o_out_proc_id  (out_proc_id),
        .o_out_priority (out_priority),
        .o_occupancy    (occupancy),
        .o_all_empty    (all_empty),
        .o_at_limit     (at_limit)
    );

    assign m_axis_tuser = accepted;
    assign m_axis_tdata = OUT_DATA_W'({at_limit, all_empty, occupancy,
                                       out_priority, out_proc_id});

endmodule
